/* rtl/bsoc_pkg.sv */
// shared constants, lookup tables and types for the battery state-of-charge interpolator
package bsoc_pkg;

	// converter and scale register
	localparam int ADC_BITS_DEF = 12;
	localparam int SCALE_W      = 17;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd68815;
	localparam int FRAC_BITS    = 16;

	// millivolt and percent fields
	localparam int MV_W  = 13;
	localparam logic [MV_W-1:0] MV_MAX = 13'd8191;
	localparam int PCT_W = 7;
	localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
	localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

	// voltage / percent curve, descending
	localparam int TABLE_POINTS = 20;
	localparam int SEG_W        = 5;
	localparam logic [MV_W-1:0] LUT_MV [TABLE_POINTS] = '{
		13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4040,
		13'd4000, 13'd3960, 13'd3920, 13'd3890, 13'd3850,
		13'd3820, 13'd3790, 13'd3770, 13'd3750, 13'd3730,
		13'd3700, 13'd3660, 13'd3580, 13'd3450, 13'd3200
	};

	// per segment k (between point k and k+1): low percent, percent step,
	// and ceil(2^RECIP_SHIFT / span) so the divide becomes a multiply
	localparam int DV_W        = 8;
	localparam int DP_W        = 4;
	localparam int NUM_W       = DP_W + DV_W;
	localparam int RC_W        = 16;
	localparam int RECIP_SHIFT = 20;
	localparam logic [PCT_W-1:0] SEG_PL [TABLE_POINTS] = '{
		7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd65, 7'd60, 7'd55, 7'd50,
		7'd45, 7'd40, 7'd35, 7'd30, 7'd25, 7'd20, 7'd15, 7'd10, 7'd0,  7'd0
	};
	localparam logic [DP_W-1:0] SEG_DP [TABLE_POINTS] = '{
		4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
		4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd10, 4'd0
	};
	localparam logic [RC_W-1:0] SEG_RECIP [TABLE_POINTS] = '{
		16'd20972, 16'd26215, 16'd34953, 16'd26215, 16'd26215,
		16'd26215, 16'd26215, 16'd34953, 16'd26215, 16'd34953,
		16'd34953, 16'd52429, 16'd52429, 16'd52429, 16'd34953,
		16'd26215, 16'd13108, 16'd8066,  16'd4195,  16'd0
	};

	// item handed from the voltage stages to the interpolation stages
	typedef struct packed {
		logic [MV_W-1:0]         mv;
		logic [TABLE_POINTS-1:0] ge;        // mv >= point k
		logic                    at_floor;  // mv <= lowest point
	} map_in_t;

endpackage

/* rtl/battery_soc_lut_interpolator_top.sv */
// top level of the battery state-of-charge lookup interpolator
//
// Each input transaction carries one raw converter sample; each output
// transaction carries the cell voltage in millivolts, (sample * scale_q16) >> 16
// saturated at 8191, and the charge percent read off a fixed 20-point
// voltage/percent curve: 100 at 4200 mV and above, 0 at 3200 mV and below,
// linear and truncated inside each segment. The block is a five-stage
// pipeline (scale multiply, saturate and compare against all curve points,
// segment select, step multiply, reciprocal multiply and output register)
// and takes one transaction per clock while the output is not stalled; the
// valid bit of each accepted sample passes through v_s1, v_s2, v_s3, v_s4
// and v_s5 in order, and v_s5 drives m_tvalid. Each stage holds its item under
// backpressure and fills bubbles on its own, so input is taken whenever the
// output register can drain. scale_q16 resets to 68815 (3.3 V reference,
// 4095 full scale, divider gain 1.303) and is written through the cfg
// channel, which is always ready; write it only while the pipeline is empty.
module battery_soc_lut_interpolator_top #(
	parameter int ADC_BITS = bsoc_pkg::ADC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// scale register write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bsoc_pkg::SCALE_W-1:0]        cfg_data,    // scale_q16
	// sample input
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((ADC_BITS + 7) / 8) * 8-1:0] s_tdata,     // adc_sample, zero pad
	// result output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [23:0]                         m_tdata      // charge_percent, cell_millivolts, zero pad
);

	localparam int PROD_W = ADC_BITS + bsoc_pkg::SCALE_W;
	localparam int UP_W   = PROD_W - bsoc_pkg::FRAC_BITS;
	localparam int OUT_W  = bsoc_pkg::PCT_W + bsoc_pkg::MV_W;

	logic [bsoc_pkg::SCALE_W-1:0] scale_q;

	logic                 v_s1, v_s2;
	logic                 rdy_s1, rdy_s2;
	logic [PROD_W-1:0]    prod_s1;
	bsoc_pkg::map_in_t    item_s2;
	bsoc_pkg::map_in_t    item_c;

	logic [UP_W-1:0]      mv_up;
	logic [31:0]          mv_wide;
	logic                 map_ready;
	logic [bsoc_pkg::PCT_W-1:0] pct;
	logic [bsoc_pkg::MV_W-1:0]  mv;

	// scale register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= bsoc_pkg::SCALE_RESET;
		end else if (cfg_valid) begin
			scale_q <= cfg_data;
		end
	end

	// per-stage ready: a stage takes a new item when empty or draining
	assign rdy_s2   = !v_s2 || map_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// s2 logic: drop fraction, saturate, compare against every curve point
	always_comb begin
		mv_up   = prod_s1[PROD_W-1:bsoc_pkg::FRAC_BITS];
		mv_wide = 32'(mv_up);
		if (mv_wide > 32'(bsoc_pkg::MV_MAX)) begin
			item_c.mv = bsoc_pkg::MV_MAX;
		end else begin
			item_c.mv = mv_wide[bsoc_pkg::MV_W-1:0];
		end
		for (int k = 0; k < bsoc_pkg::TABLE_POINTS; k++) begin
			item_c.ge[k] = (item_c.mv >= bsoc_pkg::LUT_MV[k]);
		end
		item_c.at_floor = (item_c.mv <= bsoc_pkg::LUT_MV[bsoc_pkg::TABLE_POINTS-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy_s1) begin
			prod_s1 <= PROD_W'(s_tdata[ADC_BITS-1:0]) * PROD_W'(scale_q);
		end
		if (v_s1 && rdy_s2) begin
			item_s2 <= item_c;
		end
	end

	bsoc_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (map_ready),
		.in_item   (item_s2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pct       (pct),
		.mv        (mv)
	);

	assign m_tdata = {(24 - OUT_W)'(0), mv, pct};

	// percent never leaves its range
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pct <= bsoc_pkg::PCT_FULL))
		else $error("charge percent above full");

	// top of curve saturates to full
	a_pct_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (mv >= bsoc_pkg::LUT_MV[0])) |-> (pct == bsoc_pkg::PCT_FULL))
		else $error("voltage above top point without full charge");

	// bottom of curve saturates to empty
	a_pct_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (mv <= bsoc_pkg::LUT_MV[bsoc_pkg::TABLE_POINTS-1]))
		|-> (pct == bsoc_pkg::PCT_EMPTY))
		else $error("voltage below bottom point without empty charge");

	// an empty output register means the whole pipe can advance
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register empty");

	// an item left in the last stage under stall stays put
	a_hold_mv: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(mv) && $stable(pct)))
		else $error("stalled result changed");

endmodule

/* rtl/bsoc_interp.sv */
// segment select and linear interpolation stages (s3..s5) with output register
module bsoc_interp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bsoc_pkg::map_in_t            in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bsoc_pkg::PCT_W-1:0]   pct,
	output logic [bsoc_pkg::MV_W-1:0]    mv
);

	localparam int PROD_W = bsoc_pkg::NUM_W + bsoc_pkg::RC_W;

	logic                          v_s3, v_s4, v_s5;
	logic                          rdy_s3, rdy_s4, rdy_s5;
	logic [bsoc_pkg::SEG_W-1:0]    seg_s3, seg_s4;
	logic [bsoc_pkg::DV_W-1:0]     dv_s3;
	logic [bsoc_pkg::NUM_W-1:0]    num_s4;
	logic [bsoc_pkg::MV_W-1:0]     mv_s3, mv_s4, mv_s5;
	logic                          hi_s3, hi_s4, lo_s3, lo_s4;
	logic [bsoc_pkg::PCT_W-1:0]    pct_s5;

	logic [bsoc_pkg::SEG_W-1:0]    seg_c;
	logic [bsoc_pkg::SEG_W-1:0]    lo_idx;
	logic [bsoc_pkg::MV_W-1:0]     dv_full;
	logic [PROD_W-1:0]             prod_c;
	logic [bsoc_pkg::PCT_W-1:0]    pct_c;

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	// first segment from the top whose lower point is at or below mv
	always_comb begin
		seg_c = '0;
		for (int k = bsoc_pkg::TABLE_POINTS - 1; k >= 1; k--) begin
			if (in_item.ge[k]) begin
				seg_c = bsoc_pkg::SEG_W'(k - 1);
			end
		end
		lo_idx  = seg_c + bsoc_pkg::SEG_W'(1);
		dv_full = in_item.mv - bsoc_pkg::LUT_MV[lo_idx];
	end

	always_comb begin
		prod_c = PROD_W'(num_s4) * PROD_W'(bsoc_pkg::SEG_RECIP[seg_s4]);
		if (hi_s4) begin
			pct_c = bsoc_pkg::PCT_FULL;
		end else if (lo_s4) begin
			pct_c = bsoc_pkg::PCT_EMPTY;
		end else begin
			pct_c = bsoc_pkg::SEG_PL[seg_s4]
				+ prod_c[bsoc_pkg::RECIP_SHIFT +: bsoc_pkg::PCT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= in_valid;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s3) begin
			seg_s3 <= seg_c;
			dv_s3  <= dv_full[bsoc_pkg::DV_W-1:0];
			mv_s3  <= in_item.mv;
			hi_s3  <= in_item.ge[0];
			lo_s3  <= in_item.at_floor;
		end
		if (v_s3 && rdy_s4) begin
			num_s4 <= bsoc_pkg::NUM_W'(bsoc_pkg::SEG_DP[seg_s3]) * bsoc_pkg::NUM_W'(dv_s3);
			seg_s4 <= seg_s3;
			mv_s4  <= mv_s3;
			hi_s4  <= hi_s3;
			lo_s4  <= lo_s3;
		end
		if (v_s4 && rdy_s5) begin
			pct_s5 <= pct_c;
			mv_s5  <= mv_s4;
		end
	end

	assign out_valid = v_s5;
	assign pct       = pct_s5;
	assign mv        = mv_s5;

endmodule

/* test/tb.sv */
// testbench for the battery state-of-charge lookup interpolator
`timescale 1ns / 100ps

module tb;

	localparam int SCALE_W     = bsoc_pkg::SCALE_W;
	localparam int MV_W        = bsoc_pkg::MV_W;
	localparam int PCT_W       = bsoc_pkg::PCT_W;
	localparam int FRAC_BITS   = bsoc_pkg::FRAC_BITS;
	localparam logic [SCALE_W-1:0] SCALE_RESET = bsoc_pkg::SCALE_RESET;
	localparam int SAMPLE_W    = 12;
	localparam int S_TDATA_W   = 16;
	localparam int CURVE_LAST  = 19;
	localparam int unsigned MV_SAT = 8191;
	localparam logic [SCALE_W-1:0] SCALE_UNITY = 17'd65536;
	localparam logic [SCALE_W-1:0] SCALE_TOP   = 17'd131071;
	localparam logic [SCALE_W-1:0] SCALE_ZERO  = 17'd0;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 9;
	localparam int REPORT_CAP    = 64;

	typedef enum logic {ROW_SCALE, ROW_SAMPLE} plan_op_t;

	// one expected output transaction, laid out as in m_tdata
	typedef struct packed {
		logic [MV_W-1:0]  mv;
		logic [PCT_W-1:0] pct;
	} soc_result_t;

	typedef struct packed {
		plan_op_t           op;
		logic [SCALE_W-1:0] value;     // scale for ROW_SCALE, sample for ROW_SAMPLE
		logic               typed;     // expectation written out in the row
		soc_result_t        want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [SCALE_W-1:0]   cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;    // adc_sample, zero pad
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;    // charge_percent, cell_millivolts, zero pad

	soc_result_t        pending_results[$];
	plan_row_t          stim_plan[$];
	logic [SCALE_W-1:0] scale_now;
	bit                 idle_on;
	int                 errors;
	int                 results_seen;
	int                 cycles;
	int                 ready_gap_left;
	int                 long_hold_left;
	bit                 long_hold_done;

	battery_soc_lut_interpolator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #4 clk = ~clk;

	// discharge curve, descending from full to empty
	function automatic void curve_point(input int k, output int unsigned v, output int unsigned p);
		case (k)
			0:  begin v = 4200; p = 100; end
			1:  begin v = 4150; p = 95;  end
			2:  begin v = 4110; p = 90;  end
			3:  begin v = 4080; p = 85;  end
			4:  begin v = 4040; p = 80;  end
			5:  begin v = 4000; p = 75;  end
			6:  begin v = 3960; p = 70;  end
			7:  begin v = 3920; p = 65;  end
			8:  begin v = 3890; p = 60;  end
			9:  begin v = 3850; p = 55;  end
			10: begin v = 3820; p = 50;  end
			11: begin v = 3790; p = 45;  end
			12: begin v = 3770; p = 40;  end
			13: begin v = 3750; p = 35;  end
			14: begin v = 3730; p = 30;  end
			15: begin v = 3700; p = 25;  end
			16: begin v = 3660; p = 20;  end
			17: begin v = 3580; p = 15;  end
			18: begin v = 3450; p = 10;  end
			default: begin v = 3200; p = 0; end
		endcase
	endfunction

	// millivolts from the scale multiply, then percent off the curve
	function automatic soc_result_t predict_soc(input logic [SAMPLE_W-1:0] smp,
			input logic [SCALE_W-1:0] scl);
		logic [28:0]  product;
		int unsigned  mv, vh, vl, ph, pl, pct_val;
		bit           hit;
		soc_result_t  r;
		product = smp * scl;
		mv = product >> FRAC_BITS;
		if (mv > MV_SAT)
			mv = MV_SAT;
		r.mv = mv[MV_W-1:0];
		curve_point(0, vh, ph);
		curve_point(CURVE_LAST, vl, pl);
		if (mv >= vh) begin
			pct_val = ph;
		end else if (mv <= vl) begin
			pct_val = pl;
		end else begin
			pct_val = 0;
			hit = 1'b0;
			// first segment from the top wins, so a point gives its own percent
			for (int k = 0; k < CURVE_LAST; k++) begin
				curve_point(k, vh, ph);
				curve_point(k + 1, vl, pl);
				if (!hit && mv <= vh && mv >= vl) begin
					hit = 1'b1;
					pct_val = pl + ((ph - pl) * (mv - vl)) / (vh - vl);
				end
			end
		end
		r.pct = pct_val[PCT_W-1:0];
		return r;
	endfunction

	// mostly aim inside the curve for the current scale, sometimes right on a point
	function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SCALE_W-1:0] scl);
		int unsigned target, p, s;
		if (scl != 0 && $urandom_range(0, 9) < 7) begin
			if ($urandom_range(0, 3) == 0) begin
				curve_point($urandom_range(0, CURVE_LAST), target, p);
				s = ((target << FRAC_BITS) + scl - 1) / scl;
			end else begin
				target = $urandom_range(3150, 4250);
				s = (target << FRAC_BITS) / scl;
			end
			if (s > 4095)
				s = 4095;
			return s[SAMPLE_W-1:0];
		end
		return SAMPLE_W'($urandom_range(0, 4095));
	endfunction

	task automatic add_row(input plan_op_t op, input int unsigned value, input bit typed,
			input int unsigned pct, input int unsigned mv);
		plan_row_t row;
		row.op       = op;
		row.value    = value[SCALE_W-1:0];
		row.typed    = typed;
		row.want.pct = pct[PCT_W-1:0];
		row.want.mv  = mv[MV_W-1:0];
		stim_plan.push_back(row);
	endtask

	// called just after a rising edge; returns at the edge that accepted the sample
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
			input soc_result_t typed_want);
		soc_result_t want;
		want = typed ? typed_want : predict_soc(smp, scale_now);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, smp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(want);
	endtask

	// scale is only changed with the pipeline drained
	task automatic write_scale(input logic [SCALE_W-1:0] v);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		scale_now = v;
	endtask

	initial begin : stimulus
		int                  n;
		logic [SCALE_W-1:0]  scl;
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		idle_on   = 1'b1;
		scale_now = SCALE_RESET;

		// directed part: reset scale, unity scale, both scale extremes
		add_row(ROW_SAMPLE, 0,    1, 0,   0);      // bottom of the range after reset
		add_row(ROW_SAMPLE, 4095, 1, 100, 4299);   // full-scale sample, high saturation
		add_row(ROW_SAMPLE, 1,    1, 0,   1);
		add_row(ROW_SAMPLE, 4000, 0, 0,   0);      // lands on the top point
		add_row(ROW_SAMPLE, 3048, 0, 0,   0);      // lands on the bottom point
		add_row(ROW_SAMPLE, 3049, 0, 0,   0);
		add_row(ROW_SAMPLE, 2048, 0, 0,   0);
		add_row(ROW_SCALE,  SCALE_UNITY, 0, 0, 0); // millivolts equal the sample
		add_row(ROW_SAMPLE, 4095, 0, 0,   0);
		add_row(ROW_SAMPLE, 3200, 0, 0,   0);
		add_row(ROW_SAMPLE, 3201, 0, 0,   0);
		add_row(ROW_SAMPLE, 3450, 0, 0,   0);
		add_row(ROW_SAMPLE, 3451, 0, 0,   0);
		add_row(ROW_SAMPLE, 3580, 0, 0,   0);
		add_row(ROW_SAMPLE, 3700, 0, 0,   0);
		add_row(ROW_SAMPLE, 3820, 0, 0,   0);
		add_row(ROW_SAMPLE, 4040, 0, 0,   0);
		add_row(ROW_SAMPLE, 2730, 0, 0,   0);      // alternating bit patterns
		add_row(ROW_SAMPLE, 1365, 0, 0,   0);
		add_row(ROW_SCALE,  SCALE_TOP, 0, 0, 0);
		add_row(ROW_SAMPLE, 4095, 1, 100, 8189);   // largest product
		add_row(ROW_SAMPLE, 1900, 0, 0,   0);
		add_row(ROW_SCALE,  SCALE_ZERO, 0, 0, 0);
		add_row(ROW_SAMPLE, 4095, 1, 0,   0);      // zero scale gives nothing

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_plan[i]) begin
			if (stim_plan[i].op == ROW_SCALE)
				write_scale(stim_plan[i].value);
			else
				send_sample(stim_plan[i].value[SAMPLE_W-1:0], stim_plan[i].typed,
					stim_plan[i].want);
		end

		// random part: one scale per phase, extremes first, phase 5 and the last phase without idling
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			n = 175;
			case (ph)
				0: scl = SCALE_RESET;
				1: scl = SCALE_UNITY;
				2: scl = SCALE_TOP;
				3: begin scl = SCALE_ZERO; n = 30; end
				default: scl = SCALE_W'($urandom_range(51300, 131071));
			endcase
			if (ph == RANDOM_PHASES - 1)
				scl = SCALE_RESET;
			write_scale(scl);
			idle_on = (ph != 5) && (ph != RANDOM_PHASES - 1);
			for (int j = 0; j < n; j++)
				send_sample(pick_sample(scale_now), 1'b0, '0);
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// output side: check each transaction, then decide tready for the next edge
	always @(posedge clk) begin : drain_results
		soc_result_t got;
		soc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got = m_tdata[MV_W+PCT_W-1:0];
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: unexpected result, expected none, got pct %0d mv %0d",
						$time, got.pct, got.mv);
			end else begin
				want = pending_results.pop_front();
				if (got.pct !== want.pct) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: charge_percent mismatch, expected %0d, got %0d",
							$time, want.pct, got.pct);
				end
				if (got.mv !== want.mv) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: cell_millivolts mismatch, expected %0d, got %0d",
							$time, want.mv, got.mv);
				end
			end
		end

		// one long hold so the pipeline fills and backs up into the input
		if (long_hold_left != 0) begin
			m_tready <= 1'b0;
			long_hold_left--;
		end else if (!long_hold_done && results_seen >= 300) begin
			long_hold_done = 1'b1;
			long_hold_left = 60;
			m_tready <= 1'b0;
		end else if (ready_gap_left != 0) begin
			m_tready <= 1'b0;
			ready_gap_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			ready_gap_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

/* files.f */
rtl/bsoc_pkg.sv
rtl/bsoc_interp.sv
rtl/battery_soc_lut_interpolator_top.sv
test/tb.sv
